// ===== rtl/shc_pkg.sv =====
// Shared types and codes for the serial handshake controller.
`default_nettype none

package shc_pkg;

  // Link code bytes.
  localparam logic [7:0] CODE_READY = 8'h40;  // '@' ready to send
  localparam logic [7:0] CODE_OK    = 8'h24;  // '$' ok
  localparam logic [7:0] CODE_END   = 8'h23;  // '#' end of data
  localparam logic [7:0] CODE_REL   = 8'h26;  // '&' release

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGEOVER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_RECEIVE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RESET_TIMEOUT    = 24'd1000;
  localparam logic [CFG_DATA_W-1:0] RESET_CHANGEOVER = 24'd5000;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic        rx_present;
    logic [7:0]  rx_byte;
  } shc_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;
    logic       data_request;
    logic       rx_data_valid;
    logic [7:0] rx_data_byte;
    logic       in_receive_mode;
    logic       send_busy_flag;
    logic       send_done_flag;
    logic       receive_busy_flag;
    logic       receive_done_flag;
  } shc_out_t;

endpackage

`default_nettype wire

// ===== rtl/serial_handshake_controller_top.sv =====
// Top level of the serial handshake controller: input register, step logic, result register.
`default_nettype none

// The controller takes one transfer per cycle on the input channel while
// in_stall is low and returns exactly one result transfer for each. An
// accepted item sits in an input register; once the result register is free
// or draining, a short block of logic updates the step number, mode,
// saturating elapsed-time counter and busy/done flags and loads the result
// register. Throughput is one item per clock unless out_stall holds results
// back, set by the combinational update loop through the state registers. The
// input register keeps accepting while a finished result waits in the result
// register, so in_stall only rises when both registers are full and out_stall
// is high. Configuration writes are always taken (cfg_ready is high) and are
// meant to be issued only while no item is in flight. Writing the
// start-in-receive register also loads the current mode at once.
module serial_handshake_controller_top
  import shc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire shc_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output shc_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Comparisons between the timer and the 24-bit settings use the wider width.
  localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

  // Send sequence steps.
  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_RTS     = 4'd1;
  localparam logic [3:0] S_WAIT1   = 4'd2;
  localparam logic [3:0] S_DREQ    = 4'd3;
  localparam logic [3:0] S_END     = 4'd4;
  localparam logic [3:0] S_WAIT2   = 4'd5;
  localparam logic [3:0] S_REL     = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;
  localparam logic [3:0] S_IDLE    = 4'd8;

  // Receive sequence steps.
  localparam logic [3:0] R_INIT    = 4'd0;
  localparam logic [3:0] R_WAITRTS = 4'd1;
  localparam logic [3:0] R_OK1     = 4'd2;
  localparam logic [3:0] R_DATA    = 4'd3;
  localparam logic [3:0] R_OK2     = 4'd4;
  localparam logic [3:0] R_WAITREL = 4'd5;
  localparam logic [3:0] R_DONE    = 4'd6;
  localparam logic [3:0] R_IDLE    = 4'd7;

  // Configuration registers. The start-in-receive setting acts only by
  // loading the mode when it is written, so it needs no register of its own.
  logic [CFG_DATA_W-1:0] reply_timeout_r;
  logic [CFG_DATA_W-1:0] changeover_r;
  logic                  send_enable_r;
  logic                  receive_enable_r;

  // Controller state.
  logic [3:0]            step_r, step_nxt;
  logic                  rx_mode_r, rx_mode_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  send_busy_r, send_busy_nxt;
  logic                  send_done_r, send_done_nxt;
  logic                  recv_busy_r, recv_busy_nxt;
  logic                  recv_done_r, recv_done_nxt;

  // Input and result registers.
  logic                  s1_valid_r;
  shc_in_t               s1_data_r;
  logic                  out_valid_r;
  shc_out_t              out_data_r;
  shc_out_t              res_nxt;

  logic                  in_accept;
  logic                  s1_fire;
  logic                  cfg_write;
  logic                  mode_load;

  logic [TIMER_BITS:0]   timer_sum;
  logic [TIMER_BITS-1:0] timer_sat;
  logic                  timed_out;
  logic                  changeover_due;

  // The input register moves on whenever the result register is free or draining.
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign mode_load = cfg_write && (cfg_index == REG_START_RECEIVE);

  // Saturating update of the elapsed-time counter.
  assign timer_sum = {1'b0, timer_r} + (TIMER_BITS+1)'(s1_data_r.elapsed_ms);
  assign timer_sat = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : timer_sum[TIMER_BITS-1:0];
  assign timed_out = CMP_W'(timer_sat) > CMP_W'(reply_timeout_r);

  always_comb begin
    step_nxt      = step_r;
    rx_mode_nxt   = rx_mode_r;
    timer_nxt     = timer_sat;
    send_busy_nxt = send_busy_r;
    send_done_nxt = send_done_r;
    recv_busy_nxt = recv_busy_r;
    recv_done_nxt = recv_done_r;
    res_nxt       = '0;

    if (!rx_mode_r) begin
      case (step_r)
        S_INIT, S_RTS: begin
          if (step_r == S_INIT) begin
            send_busy_nxt = 1'b1;
            send_done_nxt = 1'b0;
          end
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = CODE_READY;
          timer_nxt        = '0;
          step_nxt         = S_WAIT1;
        end
        S_WAIT1, S_WAIT2: begin
          // A wrong reply is consumed and ignored; timeout only counts on a quiet line.
          if (s1_data_r.rx_present) begin
            res_nxt.rx_taken = 1'b1;
            if (s1_data_r.rx_byte == CODE_OK) begin
              step_nxt = step_r + 4'd1;
            end
          end else if (timed_out) begin
            step_nxt = step_r - 4'd1;
          end
        end
        S_DREQ: begin
          res_nxt.data_request = 1'b1;
          step_nxt             = S_END;
        end
        S_END: begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = CODE_END;
          timer_nxt        = '0;
          step_nxt         = S_WAIT2;
        end
        S_REL: begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = CODE_REL;
          step_nxt         = S_DONE;
        end
        S_DONE: begin
          send_busy_nxt = 1'b0;
          send_done_nxt = 1'b1;
          timer_nxt     = '0;
          step_nxt      = S_IDLE;
        end
        default: begin
        end
      endcase
    end else begin
      case (step_r)
        R_INIT: begin
          recv_busy_nxt = 1'b1;
          recv_done_nxt = 1'b0;
          step_nxt      = R_WAITRTS;
        end
        R_WAITRTS: begin
          if (s1_data_r.rx_present) begin
            res_nxt.rx_taken = 1'b1;
            if (s1_data_r.rx_byte == CODE_READY) begin
              step_nxt = R_OK1;
            end
          end
        end
        R_OK1: begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = CODE_OK;
          step_nxt         = R_DATA;
        end
        R_DATA: begin
          // Every data-phase byte goes to the consumer, code bytes included.
          if (s1_data_r.rx_present) begin
            res_nxt.rx_taken      = 1'b1;
            res_nxt.rx_data_valid = 1'b1;
            res_nxt.rx_data_byte  = s1_data_r.rx_byte;
            if (s1_data_r.rx_byte == CODE_READY) begin
              step_nxt = R_WAITRTS;
            end else if (s1_data_r.rx_byte == CODE_END) begin
              step_nxt = R_OK2;
            end
          end
        end
        R_OK2: begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = CODE_OK;
          timer_nxt        = '0;
          step_nxt         = R_WAITREL;
        end
        R_WAITREL: begin
          if (s1_data_r.rx_present) begin
            res_nxt.rx_taken = 1'b1;
            if (s1_data_r.rx_byte == CODE_REL) begin
              step_nxt = R_DONE;
            end
          end else if (timed_out) begin
            step_nxt = R_OK2;
          end
        end
        R_DONE: begin
          recv_busy_nxt = 1'b0;
          recv_done_nxt = 1'b1;
          timer_nxt     = '0;
          step_nxt      = R_IDLE;
        end
        default: begin
        end
      endcase
    end

    // Mode change-over, judged on the state after the step.
    changeover_due = CMP_W'(timer_nxt) > CMP_W'(changeover_r);
    if (send_enable_r && !receive_enable_r) begin
      if (!send_busy_nxt && send_done_nxt && changeover_due) begin
        rx_mode_nxt = 1'b0;
        step_nxt    = S_INIT;
      end
    end else if (!send_enable_r && receive_enable_r) begin
      // Receive-only restarts at once, without the change-over wait.
      if (!recv_busy_nxt && recv_done_nxt) begin
        rx_mode_nxt = 1'b1;
        step_nxt    = R_INIT;
      end
    end else begin
      // Half duplex, also used when neither direction is enabled.
      if (!send_busy_nxt && send_done_nxt && changeover_due) begin
        rx_mode_nxt   = 1'b1;
        step_nxt      = R_INIT;
        send_done_nxt = 1'b0;
      end
      if (!recv_busy_nxt && recv_done_nxt && changeover_due) begin
        rx_mode_nxt   = 1'b0;
        step_nxt      = S_INIT;
        recv_done_nxt = 1'b0;
      end
    end

    res_nxt.in_receive_mode   = rx_mode_nxt;
    res_nxt.send_busy_flag    = send_busy_nxt;
    res_nxt.send_done_flag    = send_done_nxt;
    res_nxt.receive_busy_flag = recv_busy_nxt;
    res_nxt.receive_done_flag = recv_done_nxt;
  end

  // Configuration registers and the controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_timeout_r  <= RESET_TIMEOUT;
      changeover_r     <= RESET_CHANGEOVER;
      send_enable_r    <= 1'b1;
      receive_enable_r <= 1'b1;
      step_r           <= S_INIT;
      rx_mode_r        <= 1'b0;
      timer_r          <= '0;
      send_busy_r      <= 1'b0;
      send_done_r      <= 1'b0;
      recv_busy_r      <= 1'b0;
      recv_done_r      <= 1'b0;
    end else begin
      if (s1_fire) begin
        step_r      <= step_nxt;
        timer_r     <= timer_nxt;
        send_busy_r <= send_busy_nxt;
        send_done_r <= send_done_nxt;
        recv_busy_r <= recv_busy_nxt;
        recv_done_r <= recv_done_nxt;
      end
      // A write of the start-in-receive register sets the mode directly.
      if (mode_load) begin
        rx_mode_r <= cfg_data[0];
      end else if (s1_fire) begin
        rx_mode_r <= rx_mode_nxt;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_REPLY_TIMEOUT:  reply_timeout_r <= cfg_data;
          REG_CHANGEOVER:     changeover_r    <= cfg_data;
          REG_START_RECEIVE: begin
          end
          REG_SEND_ENABLE:    send_enable_r    <= cfg_data[0];
          REG_RECEIVE_ENABLE: receive_enable_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res_nxt;
    end
  end

  // The input side only stalls when both stages are full and the output is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the result register could drain");

  // A finished item always shows up in the result register next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result lost after the input register advanced");

  // Idle code fields read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.tx_valid || out_data_r.tx_byte == 8'd0) &&
                     (out_data_r.rx_data_valid || out_data_r.rx_data_byte == 8'd0)))
    else $error("byte field set without its valid flag");

  // A data request belongs to the send side, data hand-over to the receive side.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.data_request && out_data_r.rx_data_valid))
    else $error("send and receive actions in one result");

endmodule

`default_nettype wire

// ===== bench/serial_handshake_controller_top_tb.sv =====
// Self-checking testbench for the serial handshake controller with its own link predictor.
`timescale 1ns / 1ps

module serial_handshake_controller_top_tb
  import shc_pkg::*;
();

  localparam int TIMER_BITS = 24;
  localparam int LIMIT_CYCLES = 800000;
  localparam logic [CFG_DATA_W-1:0] CFG_MAX = {CFG_DATA_W{1'b1}};

  // Step numbers of the send sequence.
  localparam logic [3:0] SND_INIT     = 4'd0;
  localparam logic [3:0] SND_RTS      = 4'd1;
  localparam logic [3:0] SND_WAIT_OK1 = 4'd2;
  localparam logic [3:0] SND_DATA_REQ = 4'd3;
  localparam logic [3:0] SND_END      = 4'd4;
  localparam logic [3:0] SND_WAIT_OK2 = 4'd5;
  localparam logic [3:0] SND_RELEASE  = 4'd6;
  localparam logic [3:0] SND_DONE     = 4'd7;
  localparam logic [3:0] SND_IDLE     = 4'd8;

  // Step numbers of the receive sequence.
  localparam logic [3:0] RCV_INIT     = 4'd0;
  localparam logic [3:0] RCV_WAIT_RTS = 4'd1;
  localparam logic [3:0] RCV_OK1      = 4'd2;
  localparam logic [3:0] RCV_DATA     = 4'd3;
  localparam logic [3:0] RCV_OK2      = 4'd4;
  localparam logic [3:0] RCV_WAIT_REL = 4'd5;
  localparam logic [3:0] RCV_DONE     = 4'd6;
  localparam logic [3:0] RCV_IDLE     = 4'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  shc_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  shc_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted link state, updated whenever an item transfer is accepted.
  logic [3:0]            pred_step;
  logic                  pred_rx_mode;
  logic [TIMER_BITS-1:0] pred_timer;
  logic                  pred_send_busy;
  logic                  pred_send_done;
  logic                  pred_recv_busy;
  logic                  pred_recv_done;

  // Predicted register contents, updated whenever a register write is accepted.
  logic [CFG_DATA_W-1:0] reg_timeout;
  logic [CFG_DATA_W-1:0] reg_changeover;
  logic                  reg_start_rx;
  logic                  reg_send_en;
  logic                  reg_recv_en;

  shc_out_t pending_link_results[$];

  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  items_sent = 0;
  int  reg_writes = 0;
  bit  gaps_on;
  bit  stalls_on;

  serial_handshake_controller_top #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Watchdog expired after %0d cycles.", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Computes the result of one item and moves the predicted state on. The
  // mode switch is evaluated after the step, in the same order as the block.
  task automatic advance_link_model(input shc_in_t item, output shc_out_t res);
    logic [TIMER_BITS:0] sum;
    logic                timed_out;
    res = '0;
    sum = {1'b0, pred_timer} + (TIMER_BITS+1)'(item.elapsed_ms);
    pred_timer = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
    timed_out = pred_timer > reg_timeout;

    if (!pred_rx_mode) begin
      case (pred_step)
        SND_INIT, SND_RTS: begin
          if (pred_step == SND_INIT) begin
            pred_send_busy = 1'b1;
            pred_send_done = 1'b0;
          end
          res.tx_valid = 1'b1;
          res.tx_byte = CODE_READY;
          pred_timer = '0;
          pred_step = SND_WAIT_OK1;
        end
        SND_WAIT_OK1, SND_WAIT_OK2: begin
          // A timeout only counts when no byte is waiting.
          if (item.rx_present) begin
            res.rx_taken = 1'b1;
            if (item.rx_byte == CODE_OK) pred_step = pred_step + 4'd1;
          end else if (timed_out) begin
            pred_step = pred_step - 4'd1;
          end
        end
        SND_DATA_REQ: begin
          res.data_request = 1'b1;
          pred_step = SND_END;
        end
        SND_END: begin
          res.tx_valid = 1'b1;
          res.tx_byte = CODE_END;
          pred_timer = '0;
          pred_step = SND_WAIT_OK2;
        end
        SND_RELEASE: begin
          res.tx_valid = 1'b1;
          res.tx_byte = CODE_REL;
          pred_step = SND_DONE;
        end
        SND_DONE: begin
          pred_send_busy = 1'b0;
          pred_send_done = 1'b1;
          pred_timer = '0;
          pred_step = SND_IDLE;
        end
        default: ;
      endcase
    end else begin
      case (pred_step)
        RCV_INIT: begin
          pred_recv_busy = 1'b1;
          pred_recv_done = 1'b0;
          pred_step = RCV_WAIT_RTS;
        end
        RCV_WAIT_RTS: begin
          if (item.rx_present) begin
            res.rx_taken = 1'b1;
            if (item.rx_byte == CODE_READY) pred_step = RCV_OK1;
          end
        end
        RCV_OK1: begin
          res.tx_valid = 1'b1;
          res.tx_byte = CODE_OK;
          pred_step = RCV_DATA;
        end
        RCV_DATA: begin
          // Every data-phase byte goes to the consumer, codes included.
          if (item.rx_present) begin
            res.rx_taken = 1'b1;
            res.rx_data_valid = 1'b1;
            res.rx_data_byte = item.rx_byte;
            if (item.rx_byte == CODE_READY) pred_step = RCV_WAIT_RTS;
            else if (item.rx_byte == CODE_END) pred_step = RCV_OK2;
          end
        end
        RCV_OK2: begin
          res.tx_valid = 1'b1;
          res.tx_byte = CODE_OK;
          pred_timer = '0;
          pred_step = RCV_WAIT_REL;
        end
        RCV_WAIT_REL: begin
          if (item.rx_present) begin
            res.rx_taken = 1'b1;
            if (item.rx_byte == CODE_REL) pred_step = RCV_DONE;
          end else if (timed_out) begin
            pred_step = RCV_OK2;
          end
        end
        RCV_DONE: begin
          pred_recv_busy = 1'b0;
          pred_recv_done = 1'b1;
          pred_timer = '0;
          pred_step = RCV_IDLE;
        end
        default: ;
      endcase
    end

    if (reg_send_en && !reg_recv_en) begin
      if (!pred_send_busy && pred_send_done && pred_timer > reg_changeover) begin
        pred_rx_mode = 1'b0;
        pred_step = SND_INIT;
      end
    end else if (!reg_send_en && reg_recv_en) begin
      // Receive only restarts without waiting for the change-over time.
      if (!pred_recv_busy && pred_recv_done) begin
        pred_rx_mode = 1'b1;
        pred_step = RCV_INIT;
      end
    end else begin
      // Half duplex, which is also what happens with neither enable set.
      if (!pred_send_busy && pred_send_done && pred_timer > reg_changeover) begin
        pred_rx_mode = 1'b1;
        pred_step = RCV_INIT;
        pred_send_done = 1'b0;
      end
      if (!pred_recv_busy && pred_recv_done && pred_timer > reg_changeover) begin
        pred_rx_mode = 1'b0;
        pred_step = SND_INIT;
        pred_recv_done = 1'b0;
      end
    end

    res.in_receive_mode = pred_rx_mode;
    res.send_busy_flag = pred_send_busy;
    res.send_done_flag = pred_send_done;
    res.receive_busy_flag = pred_recv_busy;
    res.receive_done_flag = pred_recv_done;
  endtask

  function automatic shc_in_t make_item(input logic [15:0] elapsed, input logic present,
                                        input logic [7:0] rx_byte);
    shc_in_t it;
    it.elapsed_ms = elapsed;
    it.rx_present = present;
    it.rx_byte = rx_byte;
    return it;
  endfunction

  // Mostly short tick intervals, with enough long ones to hit timeouts,
  // change-overs and the ends of the field.
  function automatic logic [15:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 15));
    if (r < 85) return 16'($urandom_range(0, 1500));
    if (r < 97) return 16'($urandom_range(0, 9000));
    if (r < 98) return 16'hFFFF;
    if (r < 99) return 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] any_code();
    case ($urandom_range(0, 3))
      0: return CODE_READY;
      1: return CODE_OK;
      2: return CODE_END;
      default: return CODE_REL;
    endcase
  endfunction

  // Plays the far end of the link: most items carry the byte that the
  // predicted step is waiting for, the rest are noise.
  function automatic shc_in_t link_peer_item();
    shc_in_t    it;
    logic [7:0] wanted;
    logic       waiting;
    int         r;
    it.elapsed_ms = pick_elapsed();
    it.rx_present = 1'($urandom_range(0, 1));
    it.rx_byte = ($urandom_range(0, 1) != 0) ? any_code() : 8'($urandom_range(0, 255));
    wanted = CODE_OK;
    waiting = 1'b0;
    if (!pred_rx_mode) begin
      waiting = (pred_step == SND_WAIT_OK1) || (pred_step == SND_WAIT_OK2);
    end else begin
      case (pred_step)
        RCV_WAIT_RTS: begin
          waiting = 1'b1;
          wanted = CODE_READY;
        end
        RCV_DATA: begin
          waiting = 1'b1;
          r = $urandom_range(0, 99);
          if (r < 12) wanted = CODE_END;
          else if (r < 16) wanted = CODE_READY;
          else wanted = 8'($urandom_range(0, 255));
        end
        RCV_WAIT_REL: begin
          waiting = 1'b1;
          wanted = CODE_REL;
        end
        default: ;
      endcase
    end
    if ($urandom_range(0, 99) < 80) begin
      if (waiting) begin
        it.rx_present = ($urandom_range(0, 3) != 0);
        it.rx_byte = wanted;
      end else begin
        it.rx_present = ($urandom_range(0, 3) == 0);
      end
    end
    return it;
  endfunction

  // One-bit register value with random junk in the bits above its width.
  function automatic logic [CFG_DATA_W-1:0] noisy_flag(input logic b);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    return {junk[CFG_DATA_W-1:1], b};
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Starts and ends at a falling edge. The item transfer completes at the
  // first rising edge with in_stall low; valid stays up when no gap follows.
  task automatic send_item(input shc_in_t item);
    shc_out_t res;
    int       gap;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_link_model(item, res);
    pending_link_results.push_back(res);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops sending and waits for every predicted result to come back.
  task automatic wait_link_idle();
    in_valid <= 1'b0;
    while (pending_link_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REPLY_TIMEOUT: reg_timeout = value;
      REG_CHANGEOVER: reg_changeover = value;
      REG_START_RECEIVE: begin
        reg_start_rx = value[0];
        pred_rx_mode = value[0];
      end
      REG_SEND_ENABLE: reg_send_en = value[0];
      REG_RECEIVE_ENABLE: reg_recv_en = value[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("t=%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatch_count++;
      $display("t=%0t: %s expected %0b, got %0b", $time, name, want, got);
    end
  endtask

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : check_link_results
    shc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_link_results.size() == 0) begin
        mismatch_count++;
        $display("t=%0t: result with no expectation waiting, got %h", $time, out_data);
      end else begin
        want = pending_link_results.pop_front();
        check_flag("tx_valid", want.tx_valid, out_data.tx_valid);
        check_field("tx_byte", want.tx_byte, out_data.tx_byte);
        check_flag("rx_taken", want.rx_taken, out_data.rx_taken);
        check_flag("data_request", want.data_request, out_data.data_request);
        check_flag("rx_data_valid", want.rx_data_valid, out_data.rx_data_valid);
        check_field("rx_data_byte", want.rx_data_byte, out_data.rx_data_byte);
        check_flag("in_receive_mode", want.in_receive_mode, out_data.in_receive_mode);
        check_flag("send_busy_flag", want.send_busy_flag, out_data.send_busy_flag);
        check_flag("send_done_flag", want.send_done_flag, out_data.send_done_flag);
        check_flag("receive_busy_flag", want.receive_busy_flag,
                   out_data.receive_busy_flag);
        check_flag("receive_done_flag", want.receive_done_flag,
                   out_data.receive_done_flag);
      end
    end
  end

  // The result side holds off in random bursts: mostly short, some long,
  // and not at all while stalls are switched off.
  initial begin : result_backpressure
    int hold;
    int r;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!stalls_on) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 7);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // A whole send sequence from reset values: a wrong reply, a resend after
  // the reply timeout, a timeout while waiting for the end OK, a byte that
  // arrives while the block is busy emitting, and the change-over to receive
  // exactly at and just past its limit.
  task automatic test_send_handshake();
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd7, 1'b1, 8'hFF));
    send_item(make_item(16'd1001, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd3, 1'b1, CODE_OK));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'hFFFF, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, CODE_REL));
    send_item(make_item(16'd2, 1'b1, CODE_OK));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd5000, 1'b0, 8'h00));
    send_item(make_item(16'd1, 1'b0, 8'h00));
    wait_link_idle();
  endtask

  // The mirrored receive sequence: a stray byte while waiting for ready to
  // send, data bytes at both ends of the range, a ready to send inside the
  // data phase, a timeout while waiting for release, and the switch back.
  task automatic test_receive_handshake();
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, CODE_OK));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, CODE_READY));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, 8'h00));
    send_item(make_item(16'd0, 1'b1, 8'hFF));
    send_item(make_item(16'd0, 1'b1, CODE_READY));
    send_item(make_item(16'd0, 1'b1, CODE_READY));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, CODE_END));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd1001, 1'b0, 8'h00));
    send_item(make_item(16'd0, 1'b1, CODE_OK));
    send_item(make_item(16'd0, 1'b1, CODE_REL));
    send_item(make_item(16'd0, 1'b0, 8'h00));
    send_item(make_item(16'd5001, 1'b0, 8'h00));
    wait_link_idle();
  endtask

  // Unused register indexes, junk above the flag bits, zero timeout, and a
  // mode change by register write that leaves the block on a step that the
  // receive sequence does not have.
  task automatic test_register_access();
    int guard;
    for (int idx = REG_RECEIVE_ENABLE + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    end
    write_reg(REG_REPLY_TIMEOUT, '0);
    write_reg(REG_CHANGEOVER, CFG_MAX);
    write_reg(REG_SEND_ENABLE, noisy_flag(1'b1));
    write_reg(REG_RECEIVE_ENABLE, noisy_flag(1'b0));
    write_reg(REG_START_RECEIVE, noisy_flag(1'b0));
    guard = 0;
    while (!(pred_rx_mode == 1'b0 && pred_step == SND_IDLE) && guard < 400) begin
      send_item(link_peer_item());
      guard++;
    end
    wait_link_idle();
    write_reg(REG_START_RECEIVE, noisy_flag(1'b1));
    send_item(make_item(16'd9, 1'b1, CODE_READY));
    send_item(make_item(16'hFFFF, 1'b1, CODE_REL));
    wait_link_idle();
    write_reg(REG_START_RECEIVE, noisy_flag(1'b0));
    send_item(make_item(16'd0, 1'b1, CODE_OK));
    wait_link_idle();
  endtask

  // With both limits at maximum the timer runs into saturation in send mode.
  // Lowering the limits by one then shows at once whether it saturated or
  // wrapped: a resend or a restart follows only from a saturated timer.
  task automatic test_timer_saturation();
    write_reg(REG_REPLY_TIMEOUT, CFG_MAX);
    write_reg(REG_CHANGEOVER, CFG_MAX);
    write_reg(REG_SEND_ENABLE, noisy_flag(1'b1));
    write_reg(REG_RECEIVE_ENABLE, noisy_flag(1'b0));
    write_reg(REG_START_RECEIVE, noisy_flag(1'b0));
    repeat (270) begin
      send_item(make_item(16'($urandom_range(64000, 65535)), 1'b0,
                          8'($urandom_range(0, 255))));
    end
    wait_link_idle();
    write_reg(REG_REPLY_TIMEOUT, CFG_MAX - 1'b1);
    write_reg(REG_CHANGEOVER, CFG_MAX - 1'b1);
    repeat (3) send_item(make_item(16'd0, 1'b0, 8'h00));
    wait_link_idle();
  endtask

  // Phases of peer-driven traffic, each under its own register setting and
  // idle pattern. Now and then the sender holds off until all results are in.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] tmo;
    logic [CFG_DATA_W-1:0] chg;
    logic                  snd;
    logic                  rcv;
    logic                  start;
    for (int phase = 0; phase < 8; phase++) begin
      tmo = CFG_DATA_W'($urandom_range(0, 300));
      chg = CFG_DATA_W'($urandom_range(0, 300));
      snd = 1'b1;
      rcv = 1'b1;
      start = 1'($urandom_range(0, 1));
      case (phase)
        0: begin
          tmo = RESET_TIMEOUT;
          chg = RESET_CHANGEOVER;
          start = 1'b0;
        end
        1: begin
          tmo = '0;
          chg = '0;
          start = 1'b1;
        end
        2: tmo = CFG_MAX;
        3: rcv = 1'b0;
        4: begin
          chg = CFG_MAX;
          snd = 1'b0;
          start = 1'b1;
        end
        5: begin
          snd = 1'b0;
          rcv = 1'b0;
        end
        6: begin
          tmo = CFG_DATA_W'($urandom_range(0, 50));
          chg = CFG_DATA_W'($urandom_range(0, 50));
        end
        default: begin
          tmo = CFG_DATA_W'($urandom);
          chg = CFG_DATA_W'($urandom_range(0, 5000));
          snd = 1'($urandom_range(0, 1));
          rcv = 1'($urandom_range(0, 1));
        end
      endcase
      gaps_on = (phase % 4 == 0) || (phase % 4 == 1);
      stalls_on = (phase % 4 == 0) || (phase % 4 == 2);
      write_reg(REG_REPLY_TIMEOUT, tmo);
      write_reg(REG_CHANGEOVER, chg);
      write_reg(REG_SEND_ENABLE, noisy_flag(snd));
      write_reg(REG_RECEIVE_ENABLE, noisy_flag(rcv));
      write_reg(REG_START_RECEIVE, noisy_flag(start));
      repeat (200) begin
        send_item(link_peer_item());
        if ($urandom_range(0, 199) == 0) wait_link_idle();
      end
      wait_link_idle();
    end
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;

    // Predictor starts from the block's reset values.
    reg_timeout = RESET_TIMEOUT;
    reg_changeover = RESET_CHANGEOVER;
    reg_start_rx = 1'b0;
    reg_send_en = 1'b1;
    reg_recv_en = 1'b1;
    pred_step = SND_INIT;
    pred_rx_mode = reg_start_rx;
    pred_timer = '0;
    pred_send_busy = 1'b0;
    pred_send_done = 1'b0;
    pred_recv_busy = 1'b0;
    pred_recv_done = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_send_handshake();
    test_receive_handshake();
    test_register_access();
    test_timer_saturation();
    test_random_traffic();

    wait_link_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d items, checked %0d results, made %0d register writes.",
             items_sent, results_checked, reg_writes);
    $display("Covered both handshakes, resends, all enable modes and timer saturation.");
    if (mismatch_count == 0 && pending_link_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/shc_pkg.sv
rtl/serial_handshake_controller_top.sv
bench/serial_handshake_controller_top_tb.sv
